// ===== rtl/bgp_message_parser_unit_defines.svh =====
// Assertion macros shared by the parser checker.
// Depends on nothing; expects signals named clock and reset in the using scope.
`ifndef BGP_MESSAGE_PARSER_UNIT_DEFINES_SVH
`define BGP_MESSAGE_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define BMP_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("parser check failed");

// Next-cycle implication, disabled while reset is high.
`define BMP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("parser check failed");

`endif

// ===== rtl/bmp_pkg.sv =====
// Types, codes and record helpers of the BGP message parser.
// Used by the parser top level; depends on nothing.
`timescale 1ns / 1ps

package bmp_pkg;

   localparam logic [12:0] LIMIT_LEN    = 13'd4096;
   localparam logic [5:0]  LIMIT_BITS   = 6'd32;
   localparam logic [15:0] HEADER_BYTES = 16'd19;
   localparam logic [4:0]  MARKER_BYTES = 5'd16;
   localparam logic [5:0]  OPEN_FIXED   = 6'd29;
   localparam logic [4:0]  UPDATE_MIN   = 5'd23;
   localparam logic [7:0]  MARKER_BYTE  = 8'hFF;

   // configuration register indexes
   localparam logic [1:0] CSR_MAX_LEN   = 2'd0;
   localparam logic [1:0] CSR_MAX_BITS  = 2'd1;
   localparam logic [1:0] CSR_MIN_PLEN  = 2'd2;

   // message types
   localparam logic [7:0] MT_OPEN   = 8'd1;
   localparam logic [7:0] MT_UPDATE = 8'd2;
   localparam logic [7:0] MT_LAST   = 8'd4;

   // attribute types
   localparam logic [7:0] AT_ORIGIN  = 8'd1;
   localparam logic [7:0] AT_AS_PATH = 8'd2;
   localparam logic [7:0] AT_NHOP    = 8'd3;
   localparam logic [7:0] AT_MED     = 8'd4;
   localparam logic [7:0] AT_LPREF   = 8'd5;
   localparam logic [7:0] AT_ATOMIC  = 8'd6;
   localparam logic [7:0] AT_AGGR    = 8'd7;

   // record kinds
   localparam logic [4:0] KIND_HEADER  = 5'd0;
   localparam logic [4:0] KIND_VERSION = 5'd1;
   localparam logic [4:0] KIND_ASN     = 5'd2;
   localparam logic [4:0] KIND_HOLD    = 5'd3;
   localparam logic [4:0] KIND_BGP_ID  = 5'd4;
   localparam logic [4:0] KIND_PARAM   = 5'd5;
   localparam logic [4:0] KIND_WDRAWN  = 5'd6;
   localparam logic [4:0] KIND_ORIGIN  = 5'd7;
   localparam logic [4:0] KIND_PATH    = 5'd8;
   localparam logic [4:0] KIND_NHOP    = 5'd9;
   localparam logic [4:0] KIND_MED     = 5'd10;
   localparam logic [4:0] KIND_LPREF   = 5'd11;
   localparam logic [4:0] KIND_ATOMIC  = 5'd12;
   localparam logic [4:0] KIND_AGGR    = 5'd13;
   localparam logic [4:0] KIND_NLRI    = 5'd14;
   localparam logic [4:0] KIND_EMPTY   = 5'd15;
   localparam logic [4:0] KIND_END     = 5'd16;

   // end status codes
   localparam logic [3:0] ST_OK       = 4'd0;
   localparam logic [3:0] ST_MARKER   = 4'd1;
   localparam logic [3:0] ST_LENGTH   = 4'd2;
   localparam logic [3:0] ST_TYPE     = 4'd3;
   localparam logic [3:0] ST_PARAMS   = 4'd4;
   localparam logic [3:0] ST_PREFIX   = 4'd5;
   localparam logic [3:0] ST_ATOMIC   = 4'd6;
   localparam logic [3:0] ST_ATTR     = 4'd7;
   localparam logic [3:0] ST_NLRI     = 4'd8;
   localparam logic [3:0] ST_UNPARSED = 4'd9;

   typedef enum logic [22:0] {
      PH_IDLE    = 23'h000001,
      PH_MARKER  = 23'h000002,
      PH_LEN     = 23'h000004,
      PH_TYPE    = 23'h000008,
      PH_O_VER   = 23'h000010,
      PH_O_ASN   = 23'h000020,
      PH_O_HOLD  = 23'h000040,
      PH_O_ID    = 23'h000080,
      PH_O_PLEN  = 23'h000100,
      PH_O_PTYPE = 23'h000200,
      PH_O_PLENB = 23'h000400,
      PH_O_PVAL  = 23'h000800,
      PH_U_WLEN  = 23'h001000,
      PH_U_WPLEN = 23'h002000,
      PH_U_WPFX  = 23'h004000,
      PH_U_ALEN  = 23'h008000,
      PH_A_FLAGS = 23'h010000,
      PH_A_TYPE  = 23'h020000,
      PH_A_LEN   = 23'h040000,
      PH_A_VAL   = 23'h080000,
      PH_N_PLEN  = 23'h100000,
      PH_N_PFX   = 23'h200000,
      PH_SKIP    = 23'h400000
   } phase_type;

   typedef struct packed {
      phase_type   phase;
      logic [12:0] byte_pos;
      logic [12:0] msg_len;
      logic [7:0]  msg_type;
      logic [15:0] sec_len;
      logic [15:0] sec_used;
      logic [15:0] wdr_len;
      logic [15:0] attr_total;
      logic [31:0] acc;
      logic [15:0] bytes_left;
      logic [7:0]  attr_type;
      logic [7:0]  attr_flags;
      logic [7:0]  path_left;
   } parse_state_type;

   localparam parse_state_type PARSE_RESET = '{phase: PH_IDLE, default: '0};

   typedef struct packed {
      logic [4:0]  kind;
      logic [31:0] value;
      logic [15:0] aux;
      logic [3:0]  status;
      logic        last;
   } rec_type;

   typedef struct packed {
      rec_type    r0;
      rec_type    r1;
      logic [1:0] cnt;
   } rec_pair_type;

   function automatic rec_type mk_rec(logic [4:0] kind, logic [31:0] value,
                                      logic [15:0] aux);
      rec_type r;
      r.kind   = kind;
      r.value  = value;
      r.aux    = aux;
      r.status = ST_OK;
      r.last   = 1'b0;
      return r;
   endfunction

   function automatic rec_type end_rec(logic [12:0] pos, logic [7:0] mtype,
                                       logic [3:0] status);
      rec_type r;
      r.kind   = KIND_END;
      r.value  = {19'd0, pos};
      r.aux    = {8'd0, mtype};
      r.status = status;
      r.last   = 1'b1;
      return r;
   endfunction

   // append one record; a third record in a cycle is dropped
   function automatic rec_pair_type push(rec_pair_type p, rec_type r);
      rec_pair_type q;
      q = p;
      if (p.cnt == 2'd0) begin
         q.r0  = r;
         q.cnt = 2'd1;
      end else if (p.cnt == 2'd1) begin
         q.r1  = r;
         q.cnt = 2'd2;
      end
      return q;
   endfunction

endpackage

// ===== rtl/bgp_message_parser_unit.sv =====
// BGP-4 message parser, one byte per request, records out through a small queue.
// Depends on bmp_pkg.
`timescale 1ns / 1ps
//
// Usage:
//   req_*  : one stream byte per request; req_tuser marks the first marker byte of a
//            message. A start flag inside an unfinished message closes the old one with
//            a length error record first.
//   rsp_*  : one record per request; rsp_tlast marks the end record of a message, which
//            carries the status and the count of bytes consumed.
//   csr_*  : register writes (limits), always accepted; write only while idle.
// Each byte is decoded in the cycle it is taken and produces zero, one or two records,
// which enter a four-entry record queue; rsp_* shows the oldest record in the queue.
// Throughput: one byte per cycle while the queue has room. req_tready drops only while the
// queue holds more than two records, so a stalled receiver backs up into the byte stream
// once records fill the queue; nothing is lost.
// Reset (synchronous, active high) empties the queue, returns the parser to idle, and
// loads the default limits 4096 / 32 / 2. Bytes that arrive outside a message, or after
// an error end, are dropped with no record until the next start flag.
//
module bgp_message_parser_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] start_of_message
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [31:0] record_value, [47:32] record_aux,
                                    // [51:48] status, [55:52] zero
   output logic [4:0]  rsp_tuser,   // [4:0] record_kind
   output logic        rsp_tlast,   // last_of_message
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_data
);

   logic [12:0] max_len_ff;
   logic [5:0]  max_bits_ff;
   logic [7:0]  min_plen_ff;

   bmp_pkg::parse_state_type state_ff, state_in;
   bmp_pkg::rec_pair_type    recs;

   bmp_pkg::rec_type queue_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;

   logic req_fire, rsp_fire;

   assign req_tready = (count_ff <= 3'd2);
   assign req_fire   = req_tvalid & req_tready;
   assign rsp_fire   = rsp_tvalid & rsp_tready;
   assign csr_ready  = 1'b1;

   // limit registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff  <= bmp_pkg::LIMIT_LEN;
         max_bits_ff <= bmp_pkg::LIMIT_BITS;
         min_plen_ff <= 8'd2;
      end else if (csr_valid) begin
         unique case (csr_index)
            bmp_pkg::CSR_MAX_LEN:  max_len_ff  <= csr_data;
            bmp_pkg::CSR_MAX_BITS: max_bits_ff <= csr_data[5:0];
            bmp_pkg::CSR_MIN_PLEN: min_plen_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // byte decoder: state update and up to two records per byte
   always_comb begin : decode
      bmp_pkg::parse_state_type s;
      bmp_pkg::rec_pair_type    r;
      logic [7:0]  b;
      logic [15:0] v;
      logic [12:0] lim;
      logic [5:0]  blim;
      logic [8:0]  nb9;
      logic [3:0]  nb;
      logic [1:0]  pidx;
      logic [15:0] aidx;
      logic        ok;
      logic        bad;

      s    = state_ff;
      r    = '0;
      b    = req_tdata;
      v    = '0;
      nb9  = '0;
      nb   = '0;
      pidx = '0;
      aidx = '0;
      ok   = 1'b0;
      bad  = 1'b0;
      lim  = (max_len_ff > bmp_pkg::LIMIT_LEN) ? bmp_pkg::LIMIT_LEN : max_len_ff;
      blim = (max_bits_ff > bmp_pkg::LIMIT_BITS) ? bmp_pkg::LIMIT_BITS : max_bits_ff;

      if (req_fire) begin
         // start flag: close any open message, then restart
         if (req_tuser) begin
            if (s.phase != bmp_pkg::PH_IDLE) begin
               r = bmp_pkg::push(r, bmp_pkg::end_rec(s.byte_pos, s.msg_type,
                                                     bmp_pkg::ST_LENGTH));
            end
            s       = bmp_pkg::PARSE_RESET;
            s.phase = bmp_pkg::PH_MARKER;
         end

         if (s.phase != bmp_pkg::PH_IDLE) begin
            s.byte_pos = s.byte_pos + 13'd1;

            unique case (s.phase)
               bmp_pkg::PH_MARKER: begin
                  if (b != bmp_pkg::MARKER_BYTE) begin
                     r = bmp_pkg::push(r, bmp_pkg::end_rec(s.byte_pos, s.msg_type,
                                                           bmp_pkg::ST_MARKER));
                     s.phase = bmp_pkg::PH_IDLE;
                  end else if (s.byte_pos >= {8'd0, bmp_pkg::MARKER_BYTES}) begin
                     s.phase      = bmp_pkg::PH_LEN;
                     s.bytes_left = 16'd2;
                     s.acc        = '0;
                  end
               end
               bmp_pkg::PH_LEN: begin
                  s.acc = {s.acc[23:0], b};
                  if (s.bytes_left != 16'd0) s.bytes_left = s.bytes_left - 16'd1;
                  if (s.bytes_left == 16'd0) begin
                     v = s.acc[15:0];
                     if (v < bmp_pkg::HEADER_BYTES || v > {3'd0, lim}) begin
                        r = bmp_pkg::push(r, bmp_pkg::end_rec(s.byte_pos, s.msg_type,
                                                              bmp_pkg::ST_LENGTH));
                        s.phase = bmp_pkg::PH_IDLE;
                     end else begin
                        s.msg_len = v[12:0];
                        s.phase   = bmp_pkg::PH_TYPE;
                     end
                  end
               end
               bmp_pkg::PH_TYPE: begin
                  s.msg_type = b;
                  if (b < bmp_pkg::MT_OPEN || b > bmp_pkg::MT_LAST) begin
                     r = bmp_pkg::push(r, bmp_pkg::end_rec(s.byte_pos, s.msg_type,
                                                           bmp_pkg::ST_TYPE));
                     s.phase = bmp_pkg::PH_IDLE;
                  end else begin
                     r = bmp_pkg::push(r, bmp_pkg::mk_rec(bmp_pkg::KIND_HEADER,
                                                          {19'd0, s.msg_len}, {8'd0, b}));
                     if (b == bmp_pkg::MT_OPEN) begin
                        s.phase = bmp_pkg::PH_O_VER;
                     end else if (b == bmp_pkg::MT_UPDATE) begin
                        s.phase      = bmp_pkg::PH_U_WLEN;
                        s.bytes_left = 16'd2;
                        s.acc        = '0;
                     end else begin
                        s.phase = bmp_pkg::PH_SKIP;
                     end
                  end
               end
               bmp_pkg::PH_O_VER: begin
                  r = bmp_pkg::push(r, bmp_pkg::mk_rec(bmp_pkg::KIND_VERSION,
                                                       {24'd0, b}, 16'd0));
                  s.phase      = bmp_pkg::PH_O_ASN;
                  s.bytes_left = 16'd2;
                  s.acc        = '0;
               end
               bmp_pkg::PH_O_ASN, bmp_pkg::PH_O_HOLD: begin
                  s.acc = {s.acc[23:0], b};
                  if (s.bytes_left != 16'd0) s.bytes_left = s.bytes_left - 16'd1;
                  if (s.bytes_left == 16'd0) begin
                     if (s.phase == bmp_pkg::PH_O_ASN) begin
                        r = bmp_pkg::push(r, bmp_pkg::mk_rec(bmp_pkg::KIND_ASN,
                                                             {16'd0, s.acc[15:0]}, 16'd0));
                        s.phase      = bmp_pkg::PH_O_HOLD;
                        s.bytes_left = 16'd2;
                     end else begin
                        r = bmp_pkg::push(r, bmp_pkg::mk_rec(bmp_pkg::KIND_HOLD,
                                                             {16'd0, s.acc[15:0]}, 16'd0));
                        s.phase      = bmp_pkg::PH_O_ID;
                        s.bytes_left = 16'd4;
                     end
                     s.acc = '0;
                  end
               end
               bmp_pkg::PH_O_ID: begin
                  s.acc = {s.acc[23:0], b};
                  if (s.bytes_left != 16'd0) s.bytes_left = s.bytes_left - 16'd1;
                  if (s.bytes_left == 16'd0) s.phase = bmp_pkg::PH_O_PLEN;
               end
               bmp_pkg::PH_O_PLEN: begin
                  if (b < min_plen_ff) begin
                     r = bmp_pkg::push(r, bmp_pkg::end_rec(s.byte_pos, s.msg_type,
                                                           bmp_pkg::ST_PARAMS));
                     s.phase = bmp_pkg::PH_IDLE;
                  end else if ({5'd0, b} + {7'd0, bmp_pkg::OPEN_FIXED} != s.msg_len) begin
                     r = bmp_pkg::push(r, bmp_pkg::end_rec(s.byte_pos, s.msg_type,
                                                           bmp_pkg::ST_LENGTH));
                     s.phase = bmp_pkg::PH_IDLE;
                  end else begin
                     r = bmp_pkg::push(r, bmp_pkg::mk_rec(bmp_pkg::KIND_BGP_ID,
                                                          s.acc, {8'd0, b}));
                     s.sec_len  = {8'd0, b};
                     s.sec_used = '0;
                     s.phase    = bmp_pkg::PH_O_PTYPE;
                  end
               end
               bmp_pkg::PH_O_PTYPE: begin
                  if ({1'b0, s.sec_used} + 17'd2 > {1'b0, s.sec_len}) begin
                     r = bmp_pkg::push(r, bmp_pkg::end_rec(s.byte_pos, s.msg_type,
                                                           bmp_pkg::ST_PARAMS));
                     s.phase = bmp_pkg::PH_IDLE;
                  end else begin
                     s.sec_used  = s.sec_used + 16'd1;
                     s.attr_type = b;
                     s.phase     = bmp_pkg::PH_O_PLENB;
                  end
               end
               bmp_pkg::PH_O_PLENB: begin
                  s.sec_used = s.sec_used + 16'd1;
                  if ({1'b0, s.sec_used} + {9'd0, b} > {1'b0, s.sec_len}) begin
                     r = bmp_pkg::push(r, bmp_pkg::end_rec(s.byte_pos, s.msg_type,
                                                           bmp_pkg::ST_PARAMS));
                     s.phase = bmp_pkg::PH_IDLE;
                  end else begin
                     r = bmp_pkg::push(r, bmp_pkg::mk_rec(bmp_pkg::KIND_PARAM,
                                                          {24'd0, b}, {8'd0, s.attr_type}));
                     if (b == 8'd0) begin
                        s.phase = bmp_pkg::PH_O_PTYPE;
                     end else begin
                        s.bytes_left = {8'd0, b};
                        s.phase      = bmp_pkg::PH_O_PVAL;
                     end
                  end
               end
               bmp_pkg::PH_O_PVAL: begin
                  s.sec_used = s.sec_used + 16'd1;
                  if (s.bytes_left != 16'd0) s.bytes_left = s.bytes_left - 16'd1;
                  if (s.bytes_left == 16'd0) s.phase = bmp_pkg::PH_O_PTYPE;
               end
               bmp_pkg::PH_U_WLEN: begin
                  s.acc = {s.acc[23:0], b};
                  if (s.bytes_left != 16'd0) s.bytes_left = s.bytes_left - 16'd1;
                  if (s.bytes_left == 16'd0) begin
                     v = s.acc[15:0];
                     if ({2'd0, v} + {13'd0, bmp_pkg::UPDATE_MIN} > {5'd0, s.msg_len}) begin
                        r = bmp_pkg::push(r, bmp_pkg::end_rec(s.byte_pos, s.msg_type,
                                                              bmp_pkg::ST_NLRI));
                        s.phase = bmp_pkg::PH_IDLE;
                     end else begin
                        s.wdr_len  = v;
                        s.sec_used = '0;
                        if (s.sec_used >= s.wdr_len) begin
                           s.phase      = bmp_pkg::PH_U_ALEN;
                           s.bytes_left = 16'd2;
                           s.acc        = '0;
                        end else begin
                           s.phase = bmp_pkg::PH_U_WPLEN;
                        end
                     end
                  end
               end
               bmp_pkg::PH_U_WPLEN, bmp_pkg::PH_N_PLEN: begin
                  nb9 = ({1'b0, b} + 9'd7) >> 3;
                  nb  = nb9[3:0];
                  if (b > {2'd0, blim}) begin
                     r = bmp_pkg::push(r, bmp_pkg::end_rec(s.byte_pos, s.msg_type,
                                                           bmp_pkg::ST_PREFIX));
                     s.phase = bmp_pkg::PH_IDLE;
                  end else begin
                     if (s.phase == bmp_pkg::PH_U_WPLEN) begin
                        s.sec_used = s.sec_used + 16'd1;
                        if ({1'b0, s.sec_used} + {13'd0, nb} > {1'b0, s.wdr_len}) begin
                           r = bmp_pkg::push(r, bmp_pkg::end_rec(s.byte_pos, s.msg_type,
                                                                 bmp_pkg::ST_PREFIX));
                           s.phase = bmp_pkg::PH_IDLE;
                           bad     = 1'b1;
                        end
                     end else if ({1'b0, s.byte_pos} + {10'd0, nb} > {1'b0, s.msg_len}) begin
                        r = bmp_pkg::push(r, bmp_pkg::end_rec(s.byte_pos, s.msg_type,
                                                              bmp_pkg::ST_NLRI));
                        s.phase = bmp_pkg::PH_IDLE;
                        bad     = 1'b1;
                     end
                     if (!bad) begin
                        s.path_left  = b;
                        s.bytes_left = {12'd0, nb};
                        s.acc        = '0;
                        if (nb == 4'd0) begin
                           if (s.phase == bmp_pkg::PH_U_WPLEN) begin
                              r = bmp_pkg::push(r, bmp_pkg::mk_rec(bmp_pkg::KIND_WDRAWN,
                                                                   32'd0, {8'd0, b}));
                              if (s.sec_used >= s.wdr_len) begin
                                 s.phase      = bmp_pkg::PH_U_ALEN;
                                 s.bytes_left = 16'd2;
                                 s.acc        = '0;
                              end
                           end else begin
                              r = bmp_pkg::push(r, bmp_pkg::mk_rec(bmp_pkg::KIND_NLRI,
                                                                   32'd0, {8'd0, b}));
                           end
                        end else begin
                           s.phase = (s.phase == bmp_pkg::PH_U_WPLEN) ?
                                     bmp_pkg::PH_U_WPFX : bmp_pkg::PH_N_PFX;
                        end
                     end
                  end
               end
               bmp_pkg::PH_U_WPFX, bmp_pkg::PH_N_PFX: begin
                  if (s.phase == bmp_pkg::PH_U_WPFX) s.sec_used = s.sec_used + 16'd1;
                  // place the byte left-aligned at its index within the prefix
                  nb9  = ({1'b0, s.path_left} + 9'd7) >> 3;
                  pidx = nb9[1:0] - s.bytes_left[1:0];
                  s.acc = s.acc | ({b, 24'd0} >> {pidx, 3'd0});
                  if (s.bytes_left != 16'd0) s.bytes_left = s.bytes_left - 16'd1;
                  if (s.bytes_left == 16'd0) begin
                     if (s.phase == bmp_pkg::PH_U_WPFX) begin
                        r = bmp_pkg::push(r, bmp_pkg::mk_rec(bmp_pkg::KIND_WDRAWN,
                                                             s.acc, {8'd0, s.path_left}));
                        if (s.sec_used >= s.wdr_len) begin
                           s.phase      = bmp_pkg::PH_U_ALEN;
                           s.bytes_left = 16'd2;
                           s.acc        = '0;
                        end else begin
                           s.phase = bmp_pkg::PH_U_WPLEN;
                        end
                     end else begin
                        r = bmp_pkg::push(r, bmp_pkg::mk_rec(bmp_pkg::KIND_NLRI,
                                                             s.acc, {8'd0, s.path_left}));
                        s.phase = bmp_pkg::PH_N_PLEN;
                     end
                  end
               end
               bmp_pkg::PH_U_ALEN: begin
                  s.acc = {s.acc[23:0], b};
                  if (s.bytes_left != 16'd0) s.bytes_left = s.bytes_left - 16'd1;
                  if (s.bytes_left == 16'd0) begin
                     v = s.acc[15:0];
                     if ({2'd0, v} + {2'd0, s.wdr_len} + {13'd0, bmp_pkg::UPDATE_MIN}
                         > {5'd0, s.msg_len}) begin
                        r = bmp_pkg::push(r, bmp_pkg::end_rec(s.byte_pos, s.msg_type,
                                                              bmp_pkg::ST_NLRI));
                        s.phase = bmp_pkg::PH_IDLE;
                     end else begin
                        s.attr_total = v;
                        s.sec_used   = '0;
                        s.phase = (v == 16'd0) ? bmp_pkg::PH_N_PLEN : bmp_pkg::PH_A_FLAGS;
                     end
                  end
               end
               bmp_pkg::PH_A_FLAGS: begin
                  if ({1'b0, s.sec_used} + (b[4] ? 17'd4 : 17'd3) > {1'b0, s.attr_total})
                  begin
                     r = bmp_pkg::push(r, bmp_pkg::end_rec(s.byte_pos, s.msg_type,
                                                           bmp_pkg::ST_ATTR));
                     s.phase = bmp_pkg::PH_IDLE;
                  end else begin
                     s.sec_used   = s.sec_used + 16'd1;
                     s.attr_flags = b;
                     s.phase      = bmp_pkg::PH_A_TYPE;
                  end
               end
               bmp_pkg::PH_A_TYPE: begin
                  s.sec_used   = s.sec_used + 16'd1;
                  s.attr_type  = b;
                  s.bytes_left = s.attr_flags[4] ? 16'd2 : 16'd1;
                  s.acc        = '0;
                  s.phase      = bmp_pkg::PH_A_LEN;
               end
               bmp_pkg::PH_A_LEN: begin
                  s.sec_used = s.sec_used + 16'd1;
                  s.acc = {s.acc[23:0], b};
                  if (s.bytes_left != 16'd0) s.bytes_left = s.bytes_left - 16'd1;
                  if (s.bytes_left == 16'd0) begin
                     v = s.acc[15:0];
                     if ({1'b0, s.sec_used} + {1'b0, v} > {1'b0, s.attr_total}) begin
                        r = bmp_pkg::push(r, bmp_pkg::end_rec(s.byte_pos, s.msg_type,
                                                              bmp_pkg::ST_ATTR));
                        s.phase = bmp_pkg::PH_IDLE;
                     end else if (v == 16'd0) begin
                        if (s.attr_type == bmp_pkg::AT_ATOMIC) begin
                           r = bmp_pkg::push(r, bmp_pkg::mk_rec(bmp_pkg::KIND_ATOMIC, 32'd0,
                                                                {8'd0, bmp_pkg::AT_ATOMIC}));
                        end else begin
                           r = bmp_pkg::push(r, bmp_pkg::mk_rec(bmp_pkg::KIND_EMPTY, 32'd0,
                                                                {8'd0, s.attr_type}));
                        end
                        s.phase = (s.sec_used >= s.attr_total) ?
                                  bmp_pkg::PH_N_PLEN : bmp_pkg::PH_A_FLAGS;
                     end else if (s.attr_type == bmp_pkg::AT_ATOMIC) begin
                        r = bmp_pkg::push(r, bmp_pkg::end_rec(s.byte_pos, s.msg_type,
                                                              bmp_pkg::ST_ATOMIC));
                        s.phase = bmp_pkg::PH_IDLE;
                     end else begin
                        priority case (s.attr_type)
                           bmp_pkg::AT_ORIGIN:  ok = (v == 16'd1);
                           bmp_pkg::AT_AS_PATH: ok = (v >= 16'd2);
                           bmp_pkg::AT_NHOP,
                           bmp_pkg::AT_MED,
                           bmp_pkg::AT_LPREF:   ok = (v == 16'd4);
                           bmp_pkg::AT_AGGR:    ok = (v == 16'd6);
                           default:             ok = 1'b0;
                        endcase
                        if (!ok) begin
                           r = bmp_pkg::push(r, bmp_pkg::end_rec(s.byte_pos, s.msg_type,
                                                                 bmp_pkg::ST_ATTR));
                           s.phase = bmp_pkg::PH_IDLE;
                        end else begin
                           s.sec_len    = v;
                           s.bytes_left = v;
                           s.acc        = '0;
                           s.phase      = bmp_pkg::PH_A_VAL;
                        end
                     end
                  end
               end
               bmp_pkg::PH_A_VAL: begin
                  s.sec_used = s.sec_used + 16'd1;
                  if (s.bytes_left != 16'd0) s.bytes_left = s.bytes_left - 16'd1;
                  priority case (s.attr_type)
                     bmp_pkg::AT_ORIGIN: begin
                        r = bmp_pkg::push(r, bmp_pkg::mk_rec(bmp_pkg::KIND_ORIGIN,
                                                             {24'd0, b}, 16'd1));
                     end
                     bmp_pkg::AT_NHOP, bmp_pkg::AT_MED, bmp_pkg::AT_LPREF: begin
                        s.acc = {s.acc[23:0], b};
                        if (s.bytes_left == 16'd0) begin
                           r = bmp_pkg::push(r, bmp_pkg::mk_rec(
                              (s.attr_type == bmp_pkg::AT_NHOP) ? bmp_pkg::KIND_NHOP :
                              (s.attr_type == bmp_pkg::AT_MED)  ? bmp_pkg::KIND_MED :
                                                                  bmp_pkg::KIND_LPREF,
                              s.acc, {8'd0, s.attr_type}));
                        end
                     end
                     bmp_pkg::AT_AGGR: begin
                        s.acc = {s.acc[23:0], b};
                        // first two bytes are the aggregator ASN
                        if (s.bytes_left == 16'd4) begin
                           s.sec_len = s.acc[15:0];
                           s.acc     = '0;
                        end
                        if (s.bytes_left == 16'd0) begin
                           r = bmp_pkg::push(r, bmp_pkg::mk_rec(bmp_pkg::KIND_AGGR,
                                                                s.acc, s.sec_len));
                        end
                     end
                     default: begin
                        // AS path: segment type, count, then 2-byte ASNs
                        aidx = s.sec_len - s.bytes_left - 16'd1;
                        if (aidx == 16'd0) begin
                           s.attr_flags = b;
                        end else if (aidx == 16'd1) begin
                           if ({8'd0, b, 1'b0} + 17'd2 != {1'b0, s.sec_len}) begin
                              r = bmp_pkg::push(r, bmp_pkg::end_rec(s.byte_pos, s.msg_type,
                                                                    bmp_pkg::ST_ATTR));
                              s.phase = bmp_pkg::PH_IDLE;
                              bad     = 1'b1;
                           end else begin
                              s.path_left = b;
                              s.acc       = '0;
                           end
                        end else begin
                           s.acc = {s.acc[23:0], b};
                           if (aidx[0]) begin
                              r = bmp_pkg::push(r, bmp_pkg::mk_rec(bmp_pkg::KIND_PATH,
                                                 {16'd0, s.acc[15:0]}, {8'd0, s.attr_flags}));
                              s.acc = '0;
                              if (s.path_left != 8'd0) s.path_left = s.path_left - 8'd1;
                           end
                        end
                     end
                  endcase
                  if (!bad && s.bytes_left == 16'd0) begin
                     s.phase = (s.sec_used >= s.attr_total) ?
                               bmp_pkg::PH_N_PLEN : bmp_pkg::PH_A_FLAGS;
                  end
               end
               default: ;
            endcase

            // message boundary reached: close with the status the phase implies
            if (s.phase != bmp_pkg::PH_IDLE && s.msg_len != 13'd0 &&
                s.byte_pos == s.msg_len) begin
               if (s.phase == bmp_pkg::PH_O_PTYPE || s.phase == bmp_pkg::PH_N_PLEN) begin
                  r = bmp_pkg::push(r, bmp_pkg::end_rec(s.byte_pos, s.msg_type,
                                                        bmp_pkg::ST_OK));
               end else if (s.phase == bmp_pkg::PH_SKIP) begin
                  r = bmp_pkg::push(r, bmp_pkg::end_rec(s.byte_pos, s.msg_type,
                                                        bmp_pkg::ST_UNPARSED));
               end else begin
                  r = bmp_pkg::push(r, bmp_pkg::end_rec(s.byte_pos, s.msg_type,
                                                        bmp_pkg::ST_LENGTH));
               end
               s.phase = bmp_pkg::PH_IDLE;
            end
         end
      end

      state_in = s;
      recs     = r;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bmp_pkg::PARSE_RESET;
      end else begin
         state_ff <= state_in;
      end
   end

   // record queue: push up to two, pop one per cycle while the receiver is ready
   always_comb begin
      wr_ptr_in = wr_ptr_ff + recs.cnt;
      rd_ptr_in = rd_ptr_ff + {1'b0, rsp_fire};
      count_in  = count_ff + {1'b0, recs.cnt} - {2'd0, rsp_fire};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (recs.cnt != 2'd0) queue_ff[wr_ptr_ff] <= recs.r0;
      if (recs.cnt == 2'd2) queue_ff[wr_ptr_ff + 2'd1] <= recs.r1;
   end

   assign rsp_tvalid = (count_ff != 3'd0);
   assign rsp_tdata  = {4'd0, queue_ff[rd_ptr_ff].status, queue_ff[rd_ptr_ff].aux,
                        queue_ff[rd_ptr_ff].value};
   assign rsp_tuser  = queue_ff[rd_ptr_ff].kind;
   assign rsp_tlast  = queue_ff[rd_ptr_ff].last;

endmodule

// ===== rtl/bmp_checker.sv =====
// Port-level checks of the BGP message parser, bound to its top level.
// Depends on bmp_pkg and bgp_message_parser_unit_defines.svh.
`timescale 1ns / 1ps
`include "bgp_message_parser_unit_defines.svh"

module bmp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic [4:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // a stalled record stays put
   `BMP_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // queue comes out of reset empty
   `BMP_ASSERT_NOW(a_empty_after_reset, $past(reset), !rsp_tvalid)

   // end marker and end kind go together
   `BMP_ASSERT_NOW(a_last_is_end, rsp_tvalid,
                   rsp_tlast == (rsp_tuser == bmp_pkg::KIND_END))

   // only end records carry a status
   `BMP_ASSERT_NOW(a_status_on_end, rsp_tvalid && !rsp_tlast, rsp_tdata[51:48] == 4'd0)

endmodule

bind bgp_message_parser_unit bmp_checker u_bmp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// ===== bench/bgp_message_parser_unit_tb.sv =====
// Self-checking bench for the BGP message parser: byte stream in, decoded records out.
// Depends on bmp_pkg and bgp_message_parser_unit; predicts every record in the bench.
`timescale 1ns / 1ps

module bgp_message_parser_unit_tb;
   import bmp_pkg::*;

   localparam int unsigned CAP_LEN   = 4096;
   localparam int unsigned CAP_BITS  = 32;
   localparam int unsigned UPD_FIXED = 23;
   localparam int unsigned OPEN_BASE = 29;
   localparam int unsigned HDR_LEN   = 19;
   localparam logic [7:0]  EXT_LEN   = 8'h10;
   localparam logic [7:0]  MT_NOTIFY = 8'd3;
   localparam int          DRAIN_GAP = 16;
   localparam int          CYCLE_CAP = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic [4:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [12:0] csr_data = '0;

   bgp_message_parser_unit DUT (.*);

   always #5 clock = ~clock;

   // bench-wide bookkeeping
   int  cycles = 0;
   int  hold_until = 0;
   bit  idle_on = 1'b1;
   int  errors = 0;
   int  bytes_sent = 0;
   int  frames_sent = 0;
   int  records_seen = 0;

   // records still owed by the parser, oldest first
   rec_type pending_records[$];

   // message assembly scratch
   logic [7:0] body[$];
   logic [7:0] frame[$];
   logic [7:0] vals[$];
   logic [7:0] wdr_bytes[$];
   logic [7:0] attr_bytes[$];
   logic [7:0] nlri_bytes[$];

   // parser model: limits
   logic [12:0] lim_len;
   logic [5:0]  lim_bits;
   logic [7:0]  lim_plen;

   // parser model: decode state
   phase_type   ph;
   logic [12:0] pos;
   logic [12:0] msg_len;
   logic [7:0]  msg_type;
   logic [15:0] sec_len;
   logic [15:0] sec_used;
   logic [15:0] wdr_len;
   logic [15:0] attr_total;
   logic [31:0] acc;
   logic [15:0] left;
   logic [7:0]  attr_type;
   logic [7:0]  attr_flags;
   logic [7:0]  path_left;
   logic        err_flag;
   int          step_records;

   // ---------------------------------------------------------------- parser model

   function automatic void clear_parse();
      ph = PH_IDLE; pos = '0; msg_len = '0; msg_type = '0;
      sec_len = '0; sec_used = '0; wdr_len = '0; attr_total = '0;
      acc = '0; left = '0; attr_type = '0; attr_flags = '0; path_left = '0;
      err_flag = 1'b0;
   endfunction

   // queue one record; the parser caps a byte at two records
   function automatic void owe(logic [4:0] kind, logic [31:0] value, logic [15:0] aux,
                               logic [3:0] status, logic last);
      rec_type r;
      if (step_records >= 2) return;
      r.kind = kind; r.value = value; r.aux = aux; r.status = status; r.last = last;
      pending_records.push_back(r);
      step_records++;
   endfunction

   function automatic void close_msg(logic [3:0] status);
      owe(KIND_END, {19'd0, pos}, {8'd0, msg_type}, status, 1'b1);
      ph = PH_IDLE;
      err_flag = (status != ST_OK && status != ST_UNPARSED);
   endfunction

   function automatic bit shift_in(logic [7:0] b);
      acc = (acc << 8) | 32'(b);
      if (left != 0) left--;
      return left == 0;
   endfunction

   function automatic void open_field(int unsigned n);
      left = 16'(n);
      acc = '0;
   endfunction

   function automatic void wdr_next();
      if (sec_used >= wdr_len) begin
         ph = PH_U_ALEN;
         open_field(2);
      end else begin
         ph = PH_U_WPLEN;
      end
   endfunction

   function automatic void attr_next();
      ph = (sec_used >= attr_total) ? PH_N_PLEN : PH_A_FLAGS;
   endfunction

   function automatic void prefix_byte(logic [7:0] b);
      int unsigned nb, idx;
      nb = (int'(path_left) + 7) >> 3;
      idx = (nb - left) & 3;
      acc = acc | (32'(b) << (24 - 8 * idx));
      if (left != 0) left--;
   endfunction

   function automatic void attr_start(int unsigned len);
      bit ok;
      if (len == 0) begin
         if (attr_type == AT_ATOMIC) owe(KIND_ATOMIC, '0, 16'(AT_ATOMIC), ST_OK, 1'b0);
         else owe(KIND_EMPTY, '0, {8'd0, attr_type}, ST_OK, 1'b0);
         attr_next();
         return;
      end
      if (attr_type == AT_ATOMIC) begin
         close_msg(ST_ATOMIC);
         return;
      end
      case (attr_type)
         AT_ORIGIN:                  ok = (len == 1);
         AT_AS_PATH:                 ok = (len >= 2);
         AT_NHOP, AT_MED, AT_LPREF:  ok = (len == 4);
         AT_AGGR:                    ok = (len == 6);
         default:                    ok = 1'b0;
      endcase
      if (!ok) begin
         close_msg(ST_ATTR);
         return;
      end
      sec_len = 16'(len);
      open_field(len);
      ph = PH_A_VAL;
   endfunction

   function automatic void attr_byte(logic [7:0] b);
      int unsigned idx;
      sec_used++;
      if (left != 0) left--;
      case (attr_type)
         AT_ORIGIN: owe(KIND_ORIGIN, 32'(b), 16'(AT_ORIGIN), ST_OK, 1'b0);
         AT_NHOP, AT_MED, AT_LPREF: begin
            acc = (acc << 8) | 32'(b);
            if (left == 0) owe(5'(6 + attr_type), acc, {8'd0, attr_type}, ST_OK, 1'b0);
         end
         AT_AGGR: begin
            acc = (acc << 8) | 32'(b);
            // first two bytes are the aggregator AS, the rest the address
            if (left == 4) begin
               sec_len = acc[15:0];
               acc = '0;
            end
            if (left == 0) owe(KIND_AGGR, acc, sec_len, ST_OK, 1'b0);
         end
         default: begin
            idx = int'(sec_len) - int'(left) - 1;
            if (idx == 0) begin
               attr_flags = b;
            end else if (idx == 1) begin
               if (2 + 2 * int'(b) != int'(sec_len)) begin
                  close_msg(ST_ATTR);
                  return;
               end
               path_left = b;
               acc = '0;
            end else begin
               acc = (acc << 8) | 32'(b);
               if (idx & 1) begin
                  owe(KIND_PATH, {16'd0, acc[15:0]}, {8'd0, attr_flags}, ST_OK, 1'b0);
                  acc = '0;
                  if (path_left != 0) path_left--;
               end
            end
         end
      endcase
      if (left == 0) attr_next();
   endfunction

   function automatic void decode(logic [7:0] b);
      int unsigned v, nb, hdr, cap;
      case (ph)
         PH_MARKER: begin
            if (b != MARKER_BYTE) close_msg(ST_MARKER);
            else if (pos >= 16) begin
               ph = PH_LEN;
               open_field(2);
            end
         end
         PH_LEN: if (shift_in(b)) begin
            cap = (lim_len > CAP_LEN) ? CAP_LEN : int'(lim_len);
            v = acc[15:0];
            if (v < HDR_LEN || v > cap) close_msg(ST_LENGTH);
            else begin
               msg_len = 13'(v);
               ph = PH_TYPE;
            end
         end
         PH_TYPE: begin
            msg_type = b;
            if (b < 1 || b > MT_LAST) close_msg(ST_TYPE);
            else begin
               owe(KIND_HEADER, {19'd0, msg_len}, {8'd0, b}, ST_OK, 1'b0);
               if (b == MT_OPEN) ph = PH_O_VER;
               else if (b == MT_UPDATE) begin
                  ph = PH_U_WLEN;
                  open_field(2);
               end else ph = PH_SKIP;
            end
         end
         PH_O_VER: begin
            owe(KIND_VERSION, 32'(b), '0, ST_OK, 1'b0);
            ph = PH_O_ASN;
            open_field(2);
         end
         PH_O_ASN: if (shift_in(b)) begin
            owe(KIND_ASN, {16'd0, acc[15:0]}, '0, ST_OK, 1'b0);
            ph = PH_O_HOLD;
            open_field(2);
         end
         PH_O_HOLD: if (shift_in(b)) begin
            owe(KIND_HOLD, {16'd0, acc[15:0]}, '0, ST_OK, 1'b0);
            ph = PH_O_ID;
            open_field(4);
         end
         PH_O_ID: if (shift_in(b)) ph = PH_O_PLEN;
         PH_O_PLEN: begin
            if (b < lim_plen) close_msg(ST_PARAMS);
            else if (OPEN_BASE + int'(b) != int'(msg_len)) close_msg(ST_LENGTH);
            else begin
               owe(KIND_BGP_ID, acc, {8'd0, b}, ST_OK, 1'b0);
               sec_len = {8'd0, b};
               sec_used = '0;
               ph = PH_O_PTYPE;
            end
         end
         PH_O_PTYPE: begin
            if (int'(sec_used) + 2 > int'(sec_len)) close_msg(ST_PARAMS);
            else begin
               sec_used++;
               attr_type = b;
               ph = PH_O_PLENB;
            end
         end
         PH_O_PLENB: begin
            sec_used++;
            if (int'(sec_used) + int'(b) > int'(sec_len)) close_msg(ST_PARAMS);
            else begin
               owe(KIND_PARAM, 32'(b), {8'd0, attr_type}, ST_OK, 1'b0);
               if (b == 0) ph = PH_O_PTYPE;
               else begin
                  left = {8'd0, b};
                  ph = PH_O_PVAL;
               end
            end
         end
         PH_O_PVAL: begin
            sec_used++;
            if (left != 0) left--;
            if (left == 0) ph = PH_O_PTYPE;
         end
         PH_U_WLEN: if (shift_in(b)) begin
            v = acc[15:0];
            if (UPD_FIXED + v > int'(msg_len)) close_msg(ST_NLRI);
            else begin
               wdr_len = 16'(v);
               sec_used = '0;
               wdr_next();
            end
         end
         PH_U_WPLEN, PH_N_PLEN: begin
            cap = (lim_bits > CAP_BITS) ? CAP_BITS : int'(lim_bits);
            nb = (int'(b) + 7) >> 3;
            if (int'(b) > cap) close_msg(ST_PREFIX);
            else if (ph == PH_U_WPLEN && int'(sec_used) + 1 + nb > int'(wdr_len)) begin
               sec_used++;
               close_msg(ST_PREFIX);
            end else if (ph == PH_N_PLEN && int'(pos) + nb > int'(msg_len)) begin
               close_msg(ST_NLRI);
            end else begin
               if (ph == PH_U_WPLEN) sec_used++;
               path_left = b;
               open_field(nb);
               if (nb == 0) begin
                  if (ph == PH_U_WPLEN) begin
                     owe(KIND_WDRAWN, '0, {8'd0, b}, ST_OK, 1'b0);
                     wdr_next();
                  end else owe(KIND_NLRI, '0, {8'd0, b}, ST_OK, 1'b0);
               end else begin
                  ph = (ph == PH_U_WPLEN) ? PH_U_WPFX : PH_N_PFX;
               end
            end
         end
         PH_U_WPFX: begin
            sec_used++;
            prefix_byte(b);
            if (left == 0) begin
               owe(KIND_WDRAWN, acc, {8'd0, path_left}, ST_OK, 1'b0);
               wdr_next();
            end
         end
         PH_N_PFX: begin
            prefix_byte(b);
            if (left == 0) begin
               owe(KIND_NLRI, acc, {8'd0, path_left}, ST_OK, 1'b0);
               ph = PH_N_PLEN;
            end
         end
         PH_U_ALEN: if (shift_in(b)) begin
            v = acc[15:0];
            if (UPD_FIXED + int'(wdr_len) + v > int'(msg_len)) close_msg(ST_NLRI);
            else begin
               attr_total = 16'(v);
               sec_used = '0;
               attr_next();
            end
         end
         PH_A_FLAGS: begin
            hdr = (b & EXT_LEN) ? 4 : 3;
            if (int'(sec_used) + hdr > int'(attr_total)) close_msg(ST_ATTR);
            else begin
               sec_used++;
               attr_flags = b;
               ph = PH_A_TYPE;
            end
         end
         PH_A_TYPE: begin
            sec_used++;
            attr_type = b;
            open_field((attr_flags & EXT_LEN) ? 2 : 1);
            ph = PH_A_LEN;
         end
         PH_A_LEN: begin
            sec_used++;
            if (shift_in(b)) begin
               v = acc[15:0];
               if (int'(sec_used) + v > int'(attr_total)) close_msg(ST_ATTR);
               else attr_start(v);
            end
         end
         PH_A_VAL: attr_byte(b);
         default: ;
      endcase
   endfunction

   // advance the model by one accepted byte
   function automatic void parse_byte(logic [7:0] b, logic sof);
      step_records = 0;
      if (sof) begin
         if (ph != PH_IDLE) close_msg(ST_LENGTH);
         clear_parse();
         ph = PH_MARKER;
      end
      if (ph == PH_IDLE) return;
      pos = pos + 13'd1;
      decode(b);
      if (ph != PH_IDLE && msg_len != 0 && pos == msg_len) begin
         if (ph == PH_O_PTYPE || ph == PH_N_PLEN) close_msg(ST_OK);
         else if (ph == PH_SKIP) close_msg(ST_UNPARSED);
         else close_msg(ST_LENGTH);
      end
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
      errors++;
      $display("MISMATCH t=%0t %s: expected %0h, got %0h", $time, what, want, got);
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("timeout after %0d cycles, %0d records owed", cycles,
                  pending_records.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // compare each accepted record with the oldest one owed
   always @(posedge clock) begin
      rec_type w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         records_seen++;
         if (pending_records.size() == 0) begin
            report("unexpected record kind", '0, 32'(rsp_tuser));
         end else begin
            w = pending_records.pop_front();
            if (rsp_tuser != w.kind) report("kind", 32'(w.kind), 32'(rsp_tuser));
            if (rsp_tdata[31:0] != w.value) report("value", w.value, rsp_tdata[31:0]);
            if (rsp_tdata[47:32] != w.aux) report("aux", 32'(w.aux), 32'(rsp_tdata[47:32]));
            if (rsp_tdata[51:48] != w.status)
               report("status", 32'(w.status), 32'(rsp_tdata[51:48]));
            if (rsp_tlast != w.last) report("last", 32'(w.last), 32'(rsp_tlast));
         end
      end
   end

   // receiver: random stalls, or a solid hold-off while hold_until is ahead
   always @(negedge clock) begin
      if (cycles < hold_until) rsp_tready <= 1'b0;
      else rsp_tready <= idle_on ? ($urandom_range(99) >= 33) : 1'b1;
   end

   // ---------------------------------------------------------------- driving

   // send one byte request; entered and left at a falling edge
   task automatic send_byte(input logic [7:0] b, input logic sof);
      while (idle_on && $urandom_range(99) < 33) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= sof;
      do @(posedge clock); while (!req_tready);
      parse_byte(b, sof);
      bytes_sent++;
      @(negedge clock);
   endtask

   // drop valid, wait out every owed record and the parser's tail
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_records.size() != 0) @(posedge clock);
      repeat (DRAIN_GAP) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [12:0] data);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_MAX_LEN:  lim_len  = data;
         CSR_MAX_BITS: lim_bits = data[5:0];
         CSR_MIN_PLEN: lim_plen = data[7:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // wrap body in a header and send it; cut < 0 sends it whole, flip >= 0 damages a byte
   task automatic send_frame(input logic [7:0] mtype, input int len_delta, input int cut,
                             input int flip);
      int len;
      int n;
      len = HDR_LEN + body.size() + len_delta;
      frame.delete();
      repeat (16) frame.push_back(MARKER_BYTE);
      frame.push_back(len[15:8]);
      frame.push_back(len[7:0]);
      frame.push_back(mtype);
      foreach (body[i]) frame.push_back(body[i]);
      if (flip >= 0 && flip < frame.size()) frame[flip] ^= 8'($urandom_range(255, 1));
      n = (cut >= 0 && cut < frame.size()) ? cut : frame.size();
      for (int i = 0; i < n; i++) send_byte(frame[i], i == 0);
      frames_sent++;
   endtask

   task automatic push16(ref logic [7:0] q[$], input int v);
      q.push_back(8'(v >> 8));
      q.push_back(8'(v));
   endtask

   task automatic add_prefix(ref logic [7:0] q[$], input int bits);
      q.push_back(8'(bits));
      repeat ((bits + 7) / 8) q.push_back(8'($urandom));
   endtask

   // append one attribute holding vals; the extended flag picks a two-byte length
   task automatic add_attr(input logic [7:0] flags, input logic [7:0] atype);
      attr_bytes.push_back(flags);
      attr_bytes.push_back(atype);
      if (flags & EXT_LEN) push16(attr_bytes, vals.size());
      else attr_bytes.push_back(8'(vals.size()));
      foreach (vals[i]) attr_bytes.push_back(vals[i]);
   endtask

   task automatic rand_vals(input int n);
      vals.delete();
      repeat (n) vals.push_back(8'($urandom));
   endtask

   task automatic build_update();
      body.delete();
      push16(body, wdr_bytes.size());
      foreach (wdr_bytes[i]) body.push_back(wdr_bytes[i]);
      push16(body, attr_bytes.size());
      foreach (attr_bytes[i]) body.push_back(attr_bytes[i]);
      foreach (nlri_bytes[i]) body.push_back(nlri_bytes[i]);
   endtask

   task automatic clear_sections();
      wdr_bytes.delete();
      attr_bytes.delete();
      nlri_bytes.delete();
   endtask

   // OPEN body with nparam random parameters of up to four value bytes
   task automatic build_open(input int nparam);
      logic [7:0] params[$];
      int n;
      repeat (nparam) begin
         n = $urandom_range(4);
         params.push_back(8'($urandom));
         params.push_back(8'(n));
         repeat (n) params.push_back(8'($urandom));
      end
      body.delete();
      repeat (9) body.push_back(8'($urandom));
      body.push_back(8'(params.size()));
      foreach (params[i]) body.push_back(params[i]);
   endtask

   function automatic logic [7:0] rand_flags(bit ext);
      return (8'($urandom) & ~EXT_LEN) | (ext ? EXT_LEN : 8'h00);
   endfunction

   // one random attribute, mostly well formed
   task automatic add_rand_attr();
      int sel, cnt;
      logic [7:0] t;
      sel = $urandom_range(11);
      case (sel)
         0: begin t = AT_ORIGIN; rand_vals(1); end
         1, 2: begin
            t = AT_AS_PATH;
            cnt = $urandom_range(3);
            rand_vals(2 + 2 * cnt);
            vals[1] = 8'(cnt);
            if ($urandom_range(9) == 0) vals[1] = 8'(cnt + 1);
         end
         3: begin t = AT_NHOP; rand_vals(4); end
         4: begin t = AT_MED; rand_vals(4); end
         5: begin t = AT_LPREF; rand_vals(4); end
         6: begin t = AT_ATOMIC; rand_vals(0); end
         7: begin t = AT_AGGR; rand_vals(6); end
         8: begin t = 8'($urandom_range(255, 8)); rand_vals(0); end
         9: begin t = 8'($urandom_range(7, 1)); rand_vals(0); end
         default: begin t = 8'($urandom); rand_vals($urandom_range(7)); end
      endcase
      add_attr(rand_flags($urandom_range(1)), t);
   endtask

   function automatic int rand_bits();
      if ($urandom_range(19) == 0) return $urandom_range(255);
      return $urandom_range(32);
   endfunction

   // one random message, mostly well formed, sometimes damaged or cut short
   task automatic send_rand_message();
      int kind, len_delta, cut, flip;
      kind = $urandom_range(9);
      len_delta = 0;
      cut = -1;
      flip = -1;
      if (kind < 6) begin
         clear_sections();
         repeat ($urandom_range(2)) add_prefix(wdr_bytes, rand_bits());
         repeat ($urandom_range(4)) add_rand_attr();
         repeat ($urandom_range(3)) add_prefix(nlri_bytes, rand_bits());
         build_update();
      end else if (kind < 8) begin
         build_open($urandom_range(3));
      end else begin
         body.delete();
         repeat ($urandom_range(4)) body.push_back(8'($urandom));
      end
      case ($urandom_range(19))
         0, 1, 2: flip = $urandom_range(HDR_LEN + body.size() - 1);
         3: cut = $urandom_range(HDR_LEN + body.size() - 1, 1);
         4: len_delta = int'($urandom_range(6)) - 3;
         default: ;
      endcase
      if ($urandom_range(9) == 0) repeat ($urandom_range(3, 1)) send_byte(8'($urandom), 1'b0);
      send_frame(kind < 6 ? MT_UPDATE : kind < 8 ? MT_OPEN : 8'($urandom_range(MT_LAST, 3)),
                 len_delta, cut, flip);
   endtask

   // ---------------------------------------------------------------- tests

   // one message per parser feature and per error end
   task automatic test_directed();
      // noise before any message is ignored
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      // good OPEN with parameters
      build_open(2);
      send_frame(MT_OPEN, 0, -1, -1);
      // OPEN parameter total below the minimum
      build_open(0);
      send_frame(MT_OPEN, 0, -1, -1);
      // OPEN parameter total disagrees with the length
      build_open(1);
      send_frame(MT_OPEN, 1, -1, -1);
      // parameter longer than the parameter section
      build_open(0);
      body[9] = 8'd3;
      body.push_back(8'd2); body.push_back(8'd5); body.push_back(8'h11);
      send_frame(MT_OPEN, 0, -1, -1);
      // message ends after the version byte, before the ASN field
      body.delete();
      body.push_back(8'd4);
      send_frame(MT_OPEN, 0, -1, -1);
      // bad marker, short length, length above the limit, bad types
      body.delete();
      send_frame(MT_LAST, 0, -1, 3);
      send_frame(MT_LAST, -1, -1, -1);
      send_frame(MT_LAST, 4097 - HDR_LEN, HDR_LEN, -1);
      send_frame(8'd0, 0, -1, -1);
      send_frame(8'd5, 0, -1, -1);
      // bytes after an error end are dropped
      send_byte(8'h42, 1'b0);
      // KEEPALIVE and NOTIFICATION are skipped
      send_frame(MT_LAST, 0, -1, -1);
      body.push_back(8'd6); body.push_back(8'd1);
      send_frame(MT_NOTIFY, 0, -1, -1);
      // UPDATE with every attribute, both prefix extremes, an extended length
      clear_sections();
      add_prefix(wdr_bytes, 0);
      add_prefix(wdr_bytes, 32);
      rand_vals(1); add_attr(8'h40, AT_ORIGIN);
      rand_vals(6); vals[1] = 8'd2; add_attr(8'h50, AT_AS_PATH);
      rand_vals(4); add_attr(8'h40, AT_NHOP);
      rand_vals(4); add_attr(8'h80, AT_MED);
      rand_vals(4); add_attr(8'h40, AT_LPREF);
      rand_vals(0); add_attr(8'hC0, AT_ATOMIC);
      rand_vals(6); add_attr(8'hD0, AT_AGGR);
      rand_vals(0); add_attr(8'h80, 8'd99);
      rand_vals(2); vals[1] = 8'd0; add_attr(8'h40, AT_AS_PATH);
      add_prefix(nlri_bytes, 9);
      add_prefix(nlri_bytes, 32);
      build_update();
      send_frame(MT_UPDATE, 0, -1, -1);
      // atomic aggregate with a value, unknown type with a value, wrong origin length
      clear_sections(); rand_vals(1); add_attr(8'h40, AT_ATOMIC); build_update();
      send_frame(MT_UPDATE, 0, -1, -1);
      clear_sections(); rand_vals(2); add_attr(8'h40, 8'd200); build_update();
      send_frame(MT_UPDATE, 0, -1, -1);
      clear_sections(); rand_vals(2); add_attr(8'h40, AT_ORIGIN); build_update();
      send_frame(MT_UPDATE, 0, -1, -1);
      // prefix over the bit limit, withdrawn prefix past its section
      clear_sections(); add_prefix(nlri_bytes, 33); build_update();
      send_frame(MT_UPDATE, 0, -1, -1);
      clear_sections(); wdr_bytes.push_back(8'd24); wdr_bytes.push_back(8'h0A);
      build_update();
      send_frame(MT_UPDATE, 0, -1, -1);
      // withdrawn section past the message
      body.delete(); push16(body, 16'hFFFF); push16(body, 0);
      send_frame(MT_UPDATE, 0, -1, -1);
      // attribute header past the attribute section
      clear_sections(); attr_bytes.push_back(8'h40); attr_bytes.push_back(AT_ORIGIN);
      build_update();
      send_frame(MT_UPDATE, 0, -1, -1);
      // NLRI prefix past the message
      clear_sections(); nlri_bytes.push_back(8'd24); nlri_bytes.push_back(8'h0A);
      build_update();
      send_frame(MT_UPDATE, 0, -1, -1);
      // start flag inside an unfinished message
      build_open(1);
      send_frame(MT_OPEN, 0, 24, -1);
      send_frame(MT_OPEN, 0, -1, -1);
      drain();
   endtask

   // every register, extremes included, with traffic under each setting
   task automatic test_limits();
      logic [12:0] len_set[5]  = '{13'd19, 13'd60, 13'd4096, 13'd8191, 13'd4096};
      logic [12:0] bits_set[5] = '{13'd0, 13'd8, 13'd32, 13'd63, 13'd32};
      logic [12:0] plen_set[5] = '{13'd0, 13'd255, 13'd1, 13'd8, 13'd2};
      for (int s = 0; s < 5; s++) begin
         write_reg(CSR_MAX_LEN, len_set[s]);
         write_reg(CSR_MAX_BITS, bits_set[s]);
         write_reg(CSR_MIN_PLEN, plen_set[s]);
         repeat (6) send_rand_message();
         body.delete();
         send_frame(MT_LAST, 0, -1, -1);
      end
      drain();
   endtask

   task automatic test_random();
      repeat (40) send_rand_message();
      // a stretch with no idling on either side
      idle_on = 1'b0;
      repeat (15) send_rand_message();
      idle_on = 1'b1;
      drain();
   endtask

   // hold the receiver so the record queue fills and the byte stream stalls
   task automatic test_backpressure();
      hold_until = cycles + 300;
      repeat (4) send_rand_message();
      drain();
   endtask

   initial begin
      lim_len  = 13'(CAP_LEN);
      lim_bits = 6'(CAP_BITS);
      lim_plen = 8'd2;
      clear_parse();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed();
      test_limits();
      test_random();
      test_backpressure();

      drain();
      $display("sent %0d bytes in %0d messages, checked %0d records", bytes_sent,
               frames_sent, records_seen);
      $display("covered all record kinds, every end status and all three limits");
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
